// File: src/touch_sample_median_calibrate_macros.svh
// Assertion macros for the touch sample median / calibration block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TOUCH_SAMPLE_MEDIAN_CALIBRATE_MACROS_SVH
`define TOUCH_SAMPLE_MEDIAN_CALIBRATE_MACROS_SVH
`ifndef SYNTHESIS
// Check sampled on the rising clock edge, disabled while reset is asserted.
`define TSMC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check sampled on the rising clock edge, also live during reset.
`define TSMC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSMC_ASSERT(label, clk, rst_n, prop, msg)
`define TSMC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/tsmc_pkg.sv
// Shared types and constants for the touch sample median / calibration block.
// No dependencies; used by the interfaces, the stage modules and the top level.
package tsmc_pkg;

  localparam int WORD_W   = 16;
  localparam int RAW_W    = 12;
  localparam int COEF_W   = 32;
  localparam int FRAC_W   = 16;
  // signed coef x zero-extended raw sample
  localparam int PROD_W   = COEF_W + RAW_W + 1;
  // two products plus offset, exact
  localparam int SUM_W    = PROD_W + 2;
  localparam int SX_W     = 9;
  localparam int SY_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [RAW_W-1:0] RAW_MAX = 12'd4095;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YO   = 3'd6;

  // register reset values
  localparam logic                     RST_CAL_VALID = 1'b1;
  localparam logic signed [COEF_W-1:0] RST_COEF_XX   = 32'sd5653;
  localparam logic signed [COEF_W-1:0] RST_COEF_XY   = 32'sd0;
  localparam logic signed [COEF_W-1:0] RST_COEF_XO   = -32'sd1130600;
  localparam logic signed [COEF_W-1:0] RST_COEF_YX   = 32'sd0;
  localparam logic signed [COEF_W-1:0] RST_COEF_YY   = 32'sd4249;
  localparam logic signed [COEF_W-1:0] RST_COEF_YO   = -32'sd849800;

  typedef struct packed {
    logic                     cal_valid;
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] coef_xo;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] coef_yo;
  } cfg_t;

  typedef struct packed {
    logic              pen_before;
    logic [WORD_W-1:0] x_word_1;
    logic [WORD_W-1:0] y_word_1;
    logic [WORD_W-1:0] x_word_2;
    logic [WORD_W-1:0] y_word_2;
    logic [WORD_W-1:0] x_word_3;
    logic [WORD_W-1:0] y_word_3;
    logic              pen_after;
  } in_beat_t;

  // stage 1: filtered samples
  typedef struct packed {
    logic             pressed;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } s1_t;

  // stage 2: products
  typedef struct packed {
    logic                     pressed;
    logic [RAW_W-1:0]         raw_x;
    logic [RAW_W-1:0]         raw_y;
    logic signed [PROD_W-1:0] p_xx;
    logic signed [PROD_W-1:0] p_xy;
    logic signed [PROD_W-1:0] p_yx;
    logic signed [PROD_W-1:0] p_yy;
    logic [RAW_W-1:0]         lin_x;
    logic [RAW_W-1:0]         lin_y;
  } s2_t;

  // stage 3: affine sums
  typedef struct packed {
    logic                    pressed;
    logic [RAW_W-1:0]        raw_x;
    logic [RAW_W-1:0]        raw_y;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [RAW_W-1:0]        lin_x;
    logic [RAW_W-1:0]        lin_y;
  } s3_t;

  // stage 4: result beat
  typedef struct packed {
    logic             pressed;
    logic [SX_W-1:0]  screen_x;
    logic [SY_W-1:0]  screen_y;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } s4_t;

  // load strobes for the two-stage affine unit
  typedef struct packed {
    logic load_sum;
    logic load_out;
  } aff_ld_t;

endpackage

// File: src/tsmc_if.sv
// Valid/ready channel interfaces for sample sets in and coordinates out.
// Depends on tsmc_pkg for field widths.
interface tsmc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             pen_before;
  logic [tsmc_pkg::WORD_W-1:0]      x_word_1;
  logic [tsmc_pkg::WORD_W-1:0]      y_word_1;
  logic [tsmc_pkg::WORD_W-1:0]      x_word_2;
  logic [tsmc_pkg::WORD_W-1:0]      y_word_2;
  logic [tsmc_pkg::WORD_W-1:0]      x_word_3;
  logic [tsmc_pkg::WORD_W-1:0]      y_word_3;
  logic                             pen_after;

  modport source (
    output valid, pen_before, x_word_1, y_word_1, x_word_2, y_word_2,
           x_word_3, y_word_3, pen_after,
    input  ready
  );
  modport sink (
    input  valid, pen_before, x_word_1, y_word_1, x_word_2, y_word_2,
           x_word_3, y_word_3, pen_after,
    output ready
  );
endinterface

interface tsmc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        pressed;
  logic [tsmc_pkg::SX_W-1:0]   screen_x;
  logic [tsmc_pkg::SY_W-1:0]   screen_y;
  logic [tsmc_pkg::RAW_W-1:0]  filtered_raw_x;
  logic [tsmc_pkg::RAW_W-1:0]  filtered_raw_y;

  modport source (
    output valid, pressed, screen_x, screen_y, filtered_raw_x, filtered_raw_y,
    input  ready
  );
  modport sink (
    input  valid, pressed, screen_x, screen_y, filtered_raw_x, filtered_raw_y,
    output ready
  );
endinterface

// File: src/tsmc_median.sv
// Stage 1: word-to-sample clamp and median of three per axis, registered.
// Depends on tsmc_pkg.
module tsmc_median (
  input  logic                 clk,
  input  logic                 load,
  input  tsmc_pkg::in_beat_t   beat,
  output tsmc_pkg::s1_t        s1
);

  function automatic logic [tsmc_pkg::RAW_W-1:0] to_sample(
    input logic [tsmc_pkg::WORD_W-1:0] w
  );
    // w >> 3 exceeds 4095 only when the top bit is set
    return w[tsmc_pkg::WORD_W-1] ? tsmc_pkg::RAW_MAX : w[tsmc_pkg::WORD_W-2:3];
  endfunction

  function automatic logic [tsmc_pkg::RAW_W-1:0] med3(
    input logic [tsmc_pkg::RAW_W-1:0] a,
    input logic [tsmc_pkg::RAW_W-1:0] b,
    input logic [tsmc_pkg::RAW_W-1:0] c
  );
    logic [tsmc_pkg::RAW_W-1:0] lo;
    logic [tsmc_pkg::RAW_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  tsmc_pkg::s1_t s1_nxt;
  tsmc_pkg::s1_t s1_r;

  always_comb begin
    s1_nxt.pressed = beat.pen_before & beat.pen_after;
    s1_nxt.raw_x   = '0;
    s1_nxt.raw_y   = '0;
    // released pen zeroes the samples so everything downstream reads zero
    if (s1_nxt.pressed) begin
      s1_nxt.raw_x = med3(to_sample(beat.x_word_1), to_sample(beat.x_word_2),
                          to_sample(beat.x_word_3));
      s1_nxt.raw_y = med3(to_sample(beat.y_word_1), to_sample(beat.y_word_2),
                          to_sample(beat.y_word_3));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// File: src/tsmc_mult.sv
// Stage 2: the four affine products and the linear scale products, registered.
// Depends on tsmc_pkg.
module tsmc_mult #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic           clk,
  input  logic           load,
  input  tsmc_pkg::cfg_t cfg,
  input  tsmc_pkg::s1_t  s1,
  output tsmc_pkg::s2_t  s2
);

  localparam int DIM_W = 13;
  localparam int LIN_W = tsmc_pkg::RAW_W + DIM_W;
  localparam logic [DIM_W-1:0] W_DIM = DIM_W'(SCREEN_WIDTH);
  localparam logic [DIM_W-1:0] H_DIM = DIM_W'(SCREEN_HEIGHT);

  tsmc_pkg::s2_t s2_nxt;
  tsmc_pkg::s2_t s2_r;

  logic signed [tsmc_pkg::RAW_W:0] rx_s;
  logic signed [tsmc_pkg::RAW_W:0] ry_s;
  logic [LIN_W-1:0]                lin_px;
  logic [LIN_W-1:0]                lin_py;

  always_comb begin
    rx_s = $signed({1'b0, s1.raw_x});
    ry_s = $signed({1'b0, s1.raw_y});
    // rx * W / 4096: product stays below 2^24
    lin_px = LIN_W'(s1.raw_x) * LIN_W'(W_DIM);
    lin_py = LIN_W'(s1.raw_y) * LIN_W'(H_DIM);

    s2_nxt.pressed = s1.pressed;
    s2_nxt.raw_x   = s1.raw_x;
    s2_nxt.raw_y   = s1.raw_y;
    s2_nxt.p_xx    = tsmc_pkg::PROD_W'(cfg.coef_xx) * tsmc_pkg::PROD_W'(rx_s);
    s2_nxt.p_xy    = tsmc_pkg::PROD_W'(cfg.coef_xy) * tsmc_pkg::PROD_W'(ry_s);
    s2_nxt.p_yx    = tsmc_pkg::PROD_W'(cfg.coef_yx) * tsmc_pkg::PROD_W'(rx_s);
    s2_nxt.p_yy    = tsmc_pkg::PROD_W'(cfg.coef_yy) * tsmc_pkg::PROD_W'(ry_s);
    s2_nxt.lin_x   = lin_px[tsmc_pkg::RAW_W+11:12];
    s2_nxt.lin_y   = lin_py[tsmc_pkg::RAW_W+11:12];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

// File: src/tsmc_affine.sv
// Stages 3 and 4: affine sums, then divide by 65536, clamp and select.
// Depends on tsmc_pkg.
module tsmc_affine #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic              clk,
  input  tsmc_pkg::aff_ld_t ld,
  input  tsmc_pkg::cfg_t    cfg,
  input  tsmc_pkg::s2_t     s2,
  output tsmc_pkg::s4_t     s4
);

  localparam int SUM_W = tsmc_pkg::SUM_W;
  localparam int Q_W   = SUM_W - 1 - tsmc_pkg::FRAC_W;
  localparam logic [tsmc_pkg::RAW_W-1:0] LIM_X = tsmc_pkg::RAW_W'(SCREEN_WIDTH - 1);
  localparam logic [tsmc_pkg::RAW_W-1:0] LIM_Y = tsmc_pkg::RAW_W'(SCREEN_HEIGHT - 1);

  // Negative sums truncate toward zero to a value <= 0, which clamps to 0,
  // so only non-negative sums need the shifted quotient.
  function automatic logic [tsmc_pkg::RAW_W-1:0] clamp_q(
    input logic signed [SUM_W-1:0]  sum,
    input logic [tsmc_pkg::RAW_W-1:0] lim
  );
    logic [Q_W-1:0] q;
    q = sum[SUM_W-2:tsmc_pkg::FRAC_W];
    if (sum[SUM_W-1]) return '0;
    if (q > Q_W'(lim)) return lim;
    return q[tsmc_pkg::RAW_W-1:0];
  endfunction

  tsmc_pkg::s3_t s3_nxt;
  tsmc_pkg::s3_t s3_r;
  tsmc_pkg::s4_t s4_nxt;
  tsmc_pkg::s4_t s4_r;

  logic [tsmc_pkg::RAW_W-1:0] sx;
  logic [tsmc_pkg::RAW_W-1:0] sy;

  always_comb begin
    s3_nxt.pressed = s2.pressed;
    s3_nxt.raw_x   = s2.raw_x;
    s3_nxt.raw_y   = s2.raw_y;
    s3_nxt.lin_x   = s2.lin_x;
    s3_nxt.lin_y   = s2.lin_y;
    s3_nxt.sum_x   = SUM_W'(s2.p_xx) + SUM_W'(s2.p_xy) + SUM_W'(cfg.coef_xo);
    s3_nxt.sum_y   = SUM_W'(s2.p_yx) + SUM_W'(s2.p_yy) + SUM_W'(cfg.coef_yo);
  end

  always_comb begin
    if (cfg.cal_valid) begin
      sx = clamp_q(s3_r.sum_x, LIM_X);
      sy = clamp_q(s3_r.sum_y, LIM_Y);
    end else begin
      sx = s3_r.lin_x;
      sy = s3_r.lin_y;
    end
    s4_nxt.pressed  = s3_r.pressed;
    s4_nxt.raw_x    = s3_r.raw_x;
    s4_nxt.raw_y    = s3_r.raw_y;
    s4_nxt.screen_x = s3_r.pressed ? sx[tsmc_pkg::SX_W-1:0] : '0;
    s4_nxt.screen_y = s3_r.pressed ? sy[tsmc_pkg::SY_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (ld.load_sum) begin
      s3_r <= s3_nxt;
    end
    if (ld.load_out) begin
      s4_r <= s4_nxt;
    end
  end

  assign s4 = s4_r;

endmodule

// File: src/touch_sample_median_calibrate.sv
// Top level of the touch sample median filter and screen calibration block.
// Depends on tsmc_pkg, tsmc_if, tsmc_median, tsmc_mult, tsmc_affine and the macros header.
//
// Usage:
//  - in_ch carries one touch sample set per beat: both pen flags and three
//    16-bit conversion words per axis. out_ch returns one coordinate beat
//    per sample set, in order.
//  - cfg_we/cfg_index/cfg_wdata write the calibration registers (index 0
//    cal_valid, 1..6 the Q16 coefficients); other indexes are dropped.
//    Write only while no beat is in flight.
//  - Throughput is one beat per cycle while out_ch accepts beats; the
//    pipeline stages are clamp/median, multiply, sum, and divide/clamp/select,
//    the last of which is the output register.
//  - Each stage holds its own valid bit and loads whenever it is empty or
//    its successor moves, so bubbles are squeezed out and in_ch.ready only
//    drops when all four stages hold beats and out_ch is stalled.
//  - A stalled output beat holds unchanged; nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous) empties the pipeline and loads the
//    default calibration registers.
`include "touch_sample_median_calibrate_macros.svh"
module touch_sample_median_calibrate #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tsmc_in_if.sink                            in_ch,
  tsmc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [tsmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsmc_pkg::COEF_W-1:0]        cfg_wdata
);

  // ---------------- configuration registers ----------------
  tsmc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_valid <= tsmc_pkg::RST_CAL_VALID;
      cfg_r.coef_xx   <= tsmc_pkg::RST_COEF_XX;
      cfg_r.coef_xy   <= tsmc_pkg::RST_COEF_XY;
      cfg_r.coef_xo   <= tsmc_pkg::RST_COEF_XO;
      cfg_r.coef_yx   <= tsmc_pkg::RST_COEF_YX;
      cfg_r.coef_yy   <= tsmc_pkg::RST_COEF_YY;
      cfg_r.coef_yo   <= tsmc_pkg::RST_COEF_YO;
    end else if (cfg_we) begin
      case (cfg_index)
        tsmc_pkg::REG_CAL_VALID: cfg_r.cal_valid <= cfg_wdata[0];
        tsmc_pkg::REG_COEF_XX:   cfg_r.coef_xx   <= $signed(cfg_wdata);
        tsmc_pkg::REG_COEF_XY:   cfg_r.coef_xy   <= $signed(cfg_wdata);
        tsmc_pkg::REG_COEF_XO:   cfg_r.coef_xo   <= $signed(cfg_wdata);
        tsmc_pkg::REG_COEF_YX:   cfg_r.coef_yx   <= $signed(cfg_wdata);
        tsmc_pkg::REG_COEF_YY:   cfg_r.coef_yy   <= $signed(cfg_wdata);
        tsmc_pkg::REG_COEF_YO:   cfg_r.coef_yo   <= $signed(cfg_wdata);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // valid bit per stage; a stage loads when empty or when its successor moves
  logic v1_r, v2_r, v3_r, v4_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4 = !v4_r || out_ch.ready;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_ch.ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_ch.valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

  // ---------------- datapath ----------------
  tsmc_pkg::in_beat_t in_beat;
  tsmc_pkg::s1_t      s1;
  tsmc_pkg::s2_t      s2;
  tsmc_pkg::s4_t      s4;
  tsmc_pkg::aff_ld_t  aff_ld;

  assign in_beat.pen_before = in_ch.pen_before;
  assign in_beat.x_word_1   = in_ch.x_word_1;
  assign in_beat.y_word_1   = in_ch.y_word_1;
  assign in_beat.x_word_2   = in_ch.x_word_2;
  assign in_beat.y_word_2   = in_ch.y_word_2;
  assign in_beat.x_word_3   = in_ch.x_word_3;
  assign in_beat.y_word_3   = in_ch.y_word_3;
  assign in_beat.pen_after  = in_ch.pen_after;

  // payload registers only load when a real beat arrives
  assign aff_ld.load_sum = ld3 && v2_r;
  assign aff_ld.load_out = ld4 && v3_r;

  tsmc_median u_median (
    .clk  (clk),
    .load (ld1 && in_ch.valid),
    .beat (in_beat),
    .s1   (s1)
  );

  tsmc_mult #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_mult (
    .clk  (clk),
    .load (ld2 && v1_r),
    .cfg  (cfg_r),
    .s1   (s1),
    .s2   (s2)
  );

  tsmc_affine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_affine (
    .clk (clk),
    .ld  (aff_ld),
    .cfg (cfg_r),
    .s2  (s2),
    .s4  (s4)
  );

  assign out_ch.valid          = v4_r;
  assign out_ch.pressed        = s4.pressed;
  assign out_ch.screen_x       = s4.screen_x;
  assign out_ch.screen_y       = s4.screen_y;
  assign out_ch.filtered_raw_x = s4.raw_x;
  assign out_ch.filtered_raw_y = s4.raw_y;

  // ---------------- checks ----------------
  `TSMC_ASSERT(a_release_zero, clk, rst_n, (v4_r && !s4.pressed) |-> (s4.screen_x == '0 && s4.screen_y == '0 && s4.raw_x == '0 && s4.raw_y == '0), "released pen beat carries nonzero fields")
  `TSMC_ASSERT(a_full_when_blocked, clk, rst_n, !in_ch.ready |-> (v1_r && v2_r && v3_r && v4_r), "input blocked while pipeline has a bubble")
  `TSMC_ASSERT(a_stall_keeps_beat, clk, rst_n, (v4_r && !out_ch.ready) |=> v4_r, "stalled output beat lost")
  `TSMC_ASSERT(a_cal_write, clk, rst_n, (cfg_we && cfg_index == tsmc_pkg::REG_CAL_VALID) |=> (cfg_r.cal_valid == $past(cfg_wdata[0])), "cal_valid write not taken")

endmodule
